FILE: sv/scr_pkg.sv
// Shared types and constants for the stereo cubic resampler.
// No dependencies; imported by every module of the block.
package scr_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 32;

    localparam int STEP_W = 33;
    localparam logic [STEP_W-1:0] STEP_MIN   = 33'd4290676620;
    localparam logic [STEP_W-1:0] STEP_MAX   = 33'd4299266564;
    localparam logic [STEP_W-1:0] STEP_RESET = 33'd4294967296;

    localparam int MAX_RESULTS = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COEF,
        ST_LO,
        ST_HI,
        ST_STORE,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        MAC_IDLE,
        MAC_LOAD,
        MAC_LO,
        MAC_HI
    } t_mac_op;

    // Horner addend: b, then c, then d
    typedef enum logic [1:0] {
        TERM_B,
        TERM_C,
        TERM_D
    } t_term;

    typedef struct packed {
        t_mac_op op;
        t_term   term;
    } t_mac_ctrl;

    typedef struct packed {
        logic [1:0] base;
        logic       chan;
    } t_nbr_sel;

endpackage

FILE: sv/scr_frames.sv
// Four-frame history window, last frame of the prior block, and the
// Catmull-Rom coefficient generator. Depends on scr_pkg.
module scr_frames #(
    parameter int SAMPLE_BITS = scr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic signed [SAMPLE_BITS-1:0] i_left,
    input  logic signed [SAMPLE_BITS-1:0] i_right,
    input  logic                          i_eob,
    input  scr_pkg::t_nbr_sel             i_sel,
    output logic signed [SAMPLE_BITS+5:0] o_coef_a,
    output logic signed [SAMPLE_BITS+5:0] o_coef_b,
    output logic signed [SAMPLE_BITS+5:0] o_coef_c,
    output logic signed [SAMPLE_BITS+5:0] o_coef_d
);
    import scr_pkg::*;

    localparam int ACC_W = SAMPLE_BITS + 6;

    logic signed [SAMPLE_BITS-1:0] r_win_l [4];
    logic signed [SAMPLE_BITS-1:0] r_win_r [4];
    logic signed [SAMPLE_BITS-1:0] r_prior_l;
    logic signed [SAMPLE_BITS-1:0] r_prior_r;
    logic                          r_prior_valid;
    logic                          r_in_block;

    logic signed [SAMPLE_BITS-1:0] fill_l;
    logic signed [SAMPLE_BITS-1:0] fill_r;
    logic signed [SAMPLE_BITS-1:0] w_ch [4];
    logic signed [ACC_W-1:0]       s0, s1, s2, s3;

    // frame before the block start: prior block's last frame, else this one
    assign fill_l = r_prior_valid ? r_prior_l : i_left;
    assign fill_r = r_prior_valid ? r_prior_r : i_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_valid <= 1'b0;
            r_in_block    <= 1'b0;
        end else if (i_load) begin
            if (i_eob) begin
                r_in_block <= 1'b0;
                if (r_in_block) begin
                    r_prior_valid <= 1'b1;
                end
            end else begin
                r_in_block <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if (!r_in_block) begin
                for (int k = 0; k < 3; k++) begin
                    r_win_l[k] <= fill_l;
                    r_win_r[k] <= fill_r;
                end
            end else begin
                for (int k = 0; k < 3; k++) begin
                    r_win_l[k] <= r_win_l[k+1];
                    r_win_r[k] <= r_win_r[k+1];
                end
            end
            r_win_l[3] <= i_left;
            r_win_r[3] <= i_right;
            if (i_eob && r_in_block) begin
                r_prior_l <= i_left;
                r_prior_r <= i_right;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_ch[k] = i_sel.chan ? r_win_r[k] : r_win_l[k];
        end
    end

    // neighbors past the last window frame repeat it
    always_comb begin
        unique case (i_sel.base)
            2'd0: begin
                s0 = ACC_W'(w_ch[0]);
                s1 = ACC_W'(w_ch[1]);
                s2 = ACC_W'(w_ch[2]);
                s3 = ACC_W'(w_ch[3]);
            end
            2'd1: begin
                s0 = ACC_W'(w_ch[1]);
                s1 = ACC_W'(w_ch[2]);
                s2 = ACC_W'(w_ch[3]);
                s3 = ACC_W'(w_ch[3]);
            end
            2'd2: begin
                s0 = ACC_W'(w_ch[2]);
                s1 = ACC_W'(w_ch[3]);
                s2 = ACC_W'(w_ch[3]);
                s3 = ACC_W'(w_ch[3]);
            end
            default: begin
                s0 = ACC_W'(w_ch[3]);
                s1 = ACC_W'(w_ch[3]);
                s2 = ACC_W'(w_ch[3]);
                s3 = ACC_W'(w_ch[3]);
            end
        endcase
    end

    assign o_coef_a = s3 - s0 + ((s1 <<< 1) + s1) - ((s2 <<< 1) + s2);
    assign o_coef_b = (s0 <<< 1) - ((s1 <<< 2) + s1) + (s2 <<< 2) - s3;
    assign o_coef_c = s2 - s0;
    assign o_coef_d = s1 <<< 1;

endmodule

FILE: sv/scr_mac.sv
// Shared multiply-add unit: Horner steps acc*t + addend with t split in
// two 16-bit halves, plus final halving and saturation. Depends on scr_pkg.
module scr_mac #(
    parameter int SAMPLE_BITS = scr_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = scr_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  scr_pkg::t_mac_ctrl            i_ctrl,
    input  logic [FRAC_BITS-1:0]          i_frac,
    input  logic signed [SAMPLE_BITS+5:0] i_coef_a,
    input  logic signed [SAMPLE_BITS+5:0] i_coef_b,
    input  logic signed [SAMPLE_BITS+5:0] i_coef_c,
    input  logic signed [SAMPLE_BITS+5:0] i_coef_d,
    output logic signed [SAMPLE_BITS-1:0] o_result
);
    import scr_pkg::*;

    localparam int ACC_W  = SAMPLE_BITS + 6;
    localparam int PROD_W = ACC_W + 17;
    localparam int WIDE_W = ACC_W + FRAC_BITS + 18;
    localparam int RND_SH = FRAC_BITS - 16;

    localparam logic signed [WIDE_W-1:0] HALF  = WIDE_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W:0]    ONE_R = (ACC_W + 1)'(1);
    localparam logic signed [ACC_W:0]    SAT_HI =
        {{(ACC_W - SAMPLE_BITS + 2){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W:0]    SAT_LO = ~SAT_HI;

    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [WIDE_W-1:0] r_y, n_y;

    logic [31:0]              frac_ext;
    logic [15:0]              mul_chunk;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  addend;
    logic signed [WIDE_W-1:0] wide_sum;
    logic signed [ACC_W:0]    rounded;

    assign frac_ext  = 32'(i_frac);
    assign mul_chunk = (i_ctrl.op == MAC_HI) ? frac_ext[31:16] : frac_ext[15:0];
    assign prod      = PROD_W'(r_acc) * $signed({1'b0, mul_chunk});

    always_comb begin
        unique case (i_ctrl.term)
            TERM_B:  addend = i_coef_b;
            TERM_C:  addend = i_coef_c;
            TERM_D:  addend = i_coef_d;
            default: addend = i_coef_d;
        endcase
    end

    // low half folds in the addend above the binary point and the rounding
    // half below it; high half adds the partial sum shifted down 16
    always_comb begin
        n_acc    = r_acc;
        n_y      = r_y;
        wide_sum = r_y >>> 16;
        unique case (i_ctrl.op)
            MAC_IDLE: ;
            MAC_LOAD: n_acc = i_coef_a;
            MAC_LO:   n_y = WIDE_W'(prod) + (WIDE_W'(addend) <<< FRAC_BITS) + HALF;
            MAC_HI: begin
                wide_sum = WIDE_W'(prod) + (r_y >>> 16);
                n_acc    = ACC_W'(wide_sum >>> RND_SH);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_y   <= n_y;
    end

    assign rounded = ((ACC_W + 1)'(r_acc) + ONE_R) >>> 1;

    always_comb begin
        if (rounded > SAT_HI) begin
            o_result = SAT_HI[SAMPLE_BITS-1:0];
        end else if (rounded < SAT_LO) begin
            o_result = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            o_result = rounded[SAMPLE_BITS-1:0];
        end
    end

endmodule

FILE: sv/stereo_cubic_resampler.sv
// Stereo Catmull-Rom resampler. A frame gives n results (0 to 4); ready is high
// only between frames. Each result runs per channel on the one shared multiplier
// (load, 3 x two half-multiplies, store), stalling in ST_EMIT on back-pressure.
// The first result reaches the output register from ST_EMIT, after ST_CHECK.
// Reset is synchronous, active low: step 2^32, empty history, position three.
module stereo_cubic_resampler #(
    parameter int  SAMPLE_BITS = scr_pkg::SAMPLE_BITS_DEF,
    parameter int  FRAC_BITS   = scr_pkg::FRAC_BITS_DEF,
    localparam int TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [scr_pkg::STEP_W-1:0] i_cfg_wr_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [TDATA_W-1:0]         s_axis_tdata,  // left_sample, right_sample
    input  logic                       s_axis_tlast,  // end_of_block
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [TDATA_W-1:0]         m_axis_tdata,  // out_left, out_right
    output logic                       m_axis_tlast   // last_of_run
);
    import scr_pkg::*;

    localparam int ACC_W = SAMPLE_BITS + 6;
    localparam int POS_W = FRAC_BITS + 3;
    localparam int CNT_W = $clog2(MAX_RESULTS);

    localparam logic [POS_W-1:0] ONE_POS   = POS_W'(1) << FRAC_BITS;
    localparam logic [POS_W-1:0] THREE_POS = POS_W'(3) << FRAC_BITS;

    t_state r_state, n_state;

    logic [STEP_W-1:0]             r_step;
    logic [POS_W-1:0]              r_pos;
    logic                          r_eob;
    t_term                         r_term;
    logic                          r_chan;
    logic [CNT_W-1:0]              r_count;
    logic signed [SAMPLE_BITS-1:0] r_res_l;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_l;
    logic signed [SAMPLE_BITS-1:0] r_out_r;
    logic                          r_out_last;

    logic                          accept;
    logic                          out_free;
    logic                          out_load;
    logic [POS_W-1:0]              limit;
    logic [POS_W-1:0]              step_ext;
    logic [POS_W-1:0]              pos_next;
    logic signed [POS_W:0]         pos_diff;
    logic [POS_W-1:0]              pos_start;
    logic                          in_range;
    logic                          last;

    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;
    logic signed [ACC_W-1:0]       coef_a, coef_b, coef_c, coef_d;
    logic signed [SAMPLE_BITS-1:0] mac_result;
    t_mac_ctrl                     mac_ctrl;
    t_nbr_sel                      nbr_sel;

    assign in_left  = s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_right = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // step register, clamped to the ratio limits on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_wr_data < STEP_MIN) begin
                r_step <= STEP_MIN;
            end else if (i_cfg_wr_data > STEP_MAX) begin
                r_step <= STEP_MAX;
            end else begin
                r_step <= i_cfg_wr_data;
            end
        end
    end

    assign step_ext = POS_W'(r_step[STEP_W-1 -: FRAC_BITS+1]);
    assign limit    = r_eob ? THREE_POS : ONE_POS;
    assign in_range = r_pos < limit;
    assign pos_next = r_pos + step_ext;
    assign last     = !(pos_next < limit) || (r_count == CNT_W'(MAX_RESULTS - 1));

    // r_pos holds the position relative to window frame 1, two before the newest; a new
    // frame moves the origin by one, clamped at zero
    assign pos_diff  = $signed({1'b0, r_pos}) - $signed({1'b0, ONE_POS});
    assign pos_start = pos_diff[POS_W] ? '0 : pos_diff[POS_W-1:0];

    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_CHECK;
            ST_CHECK: n_state = in_range ? ST_COEF : ST_IDLE;
            ST_COEF:  n_state = ST_LO;
            ST_LO:    n_state = ST_HI;
            ST_HI: begin
                if (r_term == TERM_D) begin
                    n_state = r_chan ? ST_EMIT : ST_STORE;
                end else begin
                    n_state = ST_LO;
                end
            end
            ST_STORE: n_state = ST_COEF;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = last ? ST_IDLE : ST_COEF;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        mac_ctrl.op   = MAC_IDLE;
        mac_ctrl.term = r_term;
        out_load      = 1'b0;
        unique case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_CHECK: ;
            ST_COEF:  mac_ctrl.op = MAC_LOAD;
            ST_LO:    mac_ctrl.op = MAC_LO;
            ST_HI:    mac_ctrl.op = MAC_HI;
            ST_STORE: ;
            ST_EMIT:  out_load = out_free;
            default:  ;
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= THREE_POS;
            r_eob       <= 1'b0;
            r_term      <= TERM_B;
            r_chan      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_pos <= pos_start;
                r_eob <= s_axis_tlast;
            end
            unique case (r_state)
                ST_CHECK: begin
                    r_chan  <= 1'b0;
                    r_count <= '0;
                end
                ST_COEF: r_term <= TERM_B;
                ST_HI: begin
                    unique case (r_term)
                        TERM_B:  r_term <= TERM_C;
                        TERM_C:  r_term <= TERM_D;
                        default: r_term <= TERM_D;
                    endcase
                end
                ST_STORE: r_chan <= 1'b1;
                ST_EMIT: begin
                    if (out_load) begin
                        r_chan  <= 1'b0;
                        r_pos   <= pos_next;
                        r_count <= r_count + 1'b1;
                    end
                end
                default: ;
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_STORE) begin
            r_res_l <= mac_result;
        end
        if (out_load) begin
            r_out_l    <= r_res_l;
            r_out_r    <= mac_result;
            r_out_last <= last;
        end
    end

    assign nbr_sel.base = r_pos[FRAC_BITS+1:FRAC_BITS];
    assign nbr_sel.chan = r_chan;

    scr_frames #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_frames (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_left   (in_left),
        .i_right  (in_right),
        .i_eob    (s_axis_tlast),
        .i_sel    (nbr_sel),
        .o_coef_a (coef_a),
        .o_coef_b (coef_b),
        .o_coef_c (coef_c),
        .o_coef_d (coef_d)
    );

    scr_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (mac_ctrl),
        .i_frac   (r_pos[FRAC_BITS-1:0]),
        .i_coef_a (coef_a),
        .i_coef_b (coef_b),
        .i_coef_c (coef_c),
        .i_coef_d (coef_d),
        .o_result (mac_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'({r_out_r, r_out_l});
    assign m_axis_tlast  = r_out_last;

endmodule
